/* src/sccd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sccd_pkg: shared types and constants of the servo chain command decoder
// Command codes, reply codes, register indexes and the records that pass
// between the byte front end, the command queue and the servo walker.
// ----------------------------------------------------------------------------
package sccd_pkg;

	localparam int unsigned CMD_W   = 4;
	localparam int unsigned ARG_W   = 10;
	localparam int unsigned POS_W   = 10;
	localparam int unsigned ID_W    = 8;
	localparam int unsigned IDX_W   = 4;
	localparam int unsigned CNT_W   = 5;
	localparam int unsigned RTYPE_W = 2;
	localparam int unsigned IDS_W   = 128;

	// Argument values with a special meaning
	localparam logic [ARG_W-1:0] CHAIN_OFF   = 10'd1023;
	localparam logic [ARG_W-1:0] ALL_SERVOS  = 10'd256;
	localparam logic [ARG_W-1:0] CHAIN_BASE  = 10'd512;
	localparam logic [POS_W-1:0] CMD2CUR_POS = 10'h0FF;

	// Reply values
	localparam logic [POS_W-1:0] REPLY_CURRENT  = 10'd0;
	localparam logic [POS_W-1:0] REPLY_POSITION = 10'd1;
	localparam logic [POS_W-1:0] VERSION_CODE   = 10'd5;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_LISTEN    = 4'd0;
	localparam logic [CMD_W-1:0] CMD_IGNORE    = 4'd1;
	localparam logic [CMD_W-1:0] CMD_ONESHOT   = 4'd2;
	localparam logic [CMD_W-1:0] CMD_SETFLAGS  = 4'd3;
	localparam logic [CMD_W-1:0] CMD_SETPOS    = 4'd4;
	localparam logic [CMD_W-1:0] CMD_SETCACHED = 4'd5;
	localparam logic [CMD_W-1:0] CMD_QCURRENT  = 4'd6;
	localparam logic [CMD_W-1:0] CMD_QPOSITION = 4'd7;
	localparam logic [CMD_W-1:0] CMD_QVERSION  = 4'd8;

	// Reply types and result kinds
	localparam logic [RTYPE_W-1:0] RT_POSITION = 2'd0;
	localparam logic [RTYPE_W-1:0] RT_CURRENT  = 2'd1;
	localparam logic [RTYPE_W-1:0] RT_VERSION  = 2'd2;
	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_REPLY  = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] CFG_SERVOS_IN_USE = 2'd0;
	localparam logic [1:0] CFG_IDS_LOW       = 2'd1;
	localparam logic [1:0] CFG_IDS_HIGH      = 2'd2;

	// Command queue geometry
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_AW    = 1;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [ARG_W-1:0] arg;
	} cmd_entry_t;

	typedef struct packed {
		logic [CNT_W-1:0] servos_in_use;
		logic [IDS_W-1:0] ids;
	} servo_cfg_t;

endpackage
`default_nettype wire

/* src/servo_chain_command_decoder_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// servo_chain_command_decoder_top: servo chain command decoder
// Decodes two-byte servo commands and emits position updates and replies.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the two-entry command queue has room.
// A command is a byte with bit 7 low followed by a byte with bit 7 high; the
// walker then takes it from the queue and visits the active servo channels
// one per cycle, holding a channel while a new result finds the output
// register still waiting on m_tready. Results come out in servo order through
// a single output register; tlast marks the final result of a command.
// Configuration is written through the cfg channel, which is always ready;
// the user must write it only while no command is in flight, as the block
// itself does not enforce this.
module servo_chain_command_decoder_top #(
	parameter int NUM_SERVOS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // [3:0] servo_index, [13:4] value, [15:14] zero
	output logic        m_tlast,
	output logic [2:0]  m_tuser,   // [0] kind, [2:1] reply_type
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [63:0] cfg_data
);

	logic [sccd_pkg::CNT_W-1:0] servos_q;
	logic [63:0]                ids_low_q;
	logic [63:0]                ids_high_q;
	sccd_pkg::servo_cfg_t       cfg;
	logic                       push;
	sccd_pkg::cmd_entry_t       push_entry;
	logic                       q_full;
	logic                       q_empty;
	logic                       q_pop;
	sccd_pkg::cmd_entry_t       q_entry;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			servos_q   <= 5'd16;
			ids_low_q  <= '0;
			ids_high_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sccd_pkg::CFG_SERVOS_IN_USE: servos_q   <= cfg_data[sccd_pkg::CNT_W-1:0];
				sccd_pkg::CFG_IDS_LOW:       ids_low_q  <= cfg_data;
				sccd_pkg::CFG_IDS_HIGH:      ids_high_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg.servos_in_use = servos_q;
	assign cfg.ids           = {ids_high_q, ids_low_q};

	sccd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.queue_full (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	sccd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.pop_entry  (q_entry),
		.empty      (q_empty)
	);

	sccd_back #(
		.NUM_SERVOS (NUM_SERVOS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_empty  (q_empty),
		.q_entry  (q_entry),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

/* src/sccd_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sccd_front: byte framing
// Pairs a command byte (bit 7 low) with an argument byte (bit 7 high) and
// pushes the complete command into the queue.
// ----------------------------------------------------------------------------
module sccd_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	input  wire  [7:0]          s_tdata,
	input  wire                 queue_full,
	output logic                push,
	output sccd_pkg::cmd_entry_t push_entry
);

	logic                        awaiting_q;
	logic [sccd_pkg::CMD_W-1:0]  cmd_q;
	logic [2:0]                  arg_q;
	logic                        accept;

	assign s_tready = !queue_full;
	assign accept   = s_tvalid && s_tready;

	// Push on a closing byte with bit 7 high
	assign push             = accept && awaiting_q && s_tdata[7];
	assign push_entry.cmd   = cmd_q;
	assign push_entry.arg   = {s_tdata[6:0], arg_q};

	// Track the frame and keep the low argument bits between frames
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			cmd_q      <= '0;
			arg_q      <= '0;
		end else if (accept) begin
			if (!awaiting_q) begin
				if (!s_tdata[7]) begin
					awaiting_q <= 1'b1;
					cmd_q      <= s_tdata[6:3];
					arg_q      <= s_tdata[2:0];
				end
			end else begin
				awaiting_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* src/sccd_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sccd_queue: command queue
// Short first-in first-out buffer between the framing front end and the
// servo walker.
// ----------------------------------------------------------------------------
module sccd_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  sccd_pkg::cmd_entry_t push_entry,
	output logic                 full,
	input  wire                  pop,
	output sccd_pkg::cmd_entry_t pop_entry,
	output logic                 empty
);

	sccd_pkg::cmd_entry_t             mem_q [sccd_pkg::QUEUE_DEPTH];
	logic [sccd_pkg::QUEUE_AW-1:0]    wr_ptr_q;
	logic [sccd_pkg::QUEUE_AW-1:0]    rd_ptr_q;
	logic [sccd_pkg::QUEUE_AW:0]      count_q;

	assign full      = (count_q == (sccd_pkg::QUEUE_AW+1)'(sccd_pkg::QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign pop_entry = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if ((push && !full) && !(pop && !empty)) begin
				count_q <= count_q + 1'b1;
			end else if (!(push && !full) && (pop && !empty)) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* src/sccd_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sccd_back: servo walker
// Runs one queued command, visiting the active servo channels one per cycle
// unless a result waits, updating flags and positions and emitting results.
// ----------------------------------------------------------------------------
module sccd_back #(
	parameter int NUM_SERVOS = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  sccd_pkg::servo_cfg_t cfg,
	input  wire                  q_empty,
	input  sccd_pkg::cmd_entry_t q_entry,
	output logic                 q_pop,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [15:0]          m_tdata,
	output logic                 m_tlast,
	output logic [2:0]           m_tuser
);

	localparam int IW = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
	localparam logic [sccd_pkg::CNT_W-1:0] NS = sccd_pkg::CNT_W'(NUM_SERVOS);

	// Per-servo state; a commanded position is only ever reported as it is
	// written, so it leaves the block on the result stream and is not stored
	logic [1:0]                   flags_q  [NUM_SERVOS];
	logic [sccd_pkg::POS_W-1:0]   cached_q [NUM_SERVOS];

	// Command in progress
	logic                         busy_q;
	logic [sccd_pkg::CMD_W-1:0]   cmd_q;
	logic [sccd_pkg::ARG_W-1:0]   arg_q;
	logic [sccd_pkg::ARG_W-1:0]   tgt_q;
	logic [sccd_pkg::ARG_W-1:0]   chain_q;
	logic                         chain_en_q;
	logic                         found_q;
	logic [sccd_pkg::CNT_W-1:0]   cnt_q;

	// Output register
	logic                         out_valid_q;
	logic                         out_kind_q;
	logic [sccd_pkg::IDX_W-1:0]   out_idx_q;
	logic [sccd_pkg::POS_W-1:0]   out_val_q;
	logic [sccd_pkg::RTYPE_W-1:0] out_rtype_q;
	logic                         out_last_q;

	logic [sccd_pkg::CNT_W-1:0]   n_act;
	logic [IW-1:0]                idx;
	logic [sccd_pkg::ID_W-1:0]    id_i;
	logic                         walking;
	logic                         match;
	logic [1:0]                   flag_i;
	logic                         fnz;
	logic [1:0]                   flag_n;
	logic                         wr_pos;
	logic                         wr_cache;
	logic [sccd_pkg::POS_W-1:0]   pos_n;
	logic                         emit;
	logic                         emit_kind;
	logic [sccd_pkg::POS_W-1:0]   emit_val;
	logic [sccd_pkg::RTYPE_W-1:0] emit_rtype;
	logic                         emit_last;
	logic [NUM_SERVOS-1:0]        later_wr;
	logic                         out_free;
	logic                         step;
	logic [sccd_pkg::ARG_W-1:0]   chain_next;
	logic                         is_posupd;

	assign n_act    = (cfg.servos_in_use > NS) ? NS : cfg.servos_in_use;
	assign walking  = busy_q && (cnt_q < n_act);
	assign idx      = cnt_q[IW-1:0];
	assign id_i     = cfg.ids[{idx, 3'b000} +: sccd_pkg::ID_W];
	assign match    = ({2'b00, id_i} == tgt_q) && !found_q;
	assign flag_i   = flags_q[idx];
	assign fnz      = (flag_i != 2'b00);
	assign out_free = !out_valid_q || m_tready;
	assign step     = walking && (!emit || out_free);
	assign q_pop    = !busy_q && !q_empty;
	assign chain_next = chain_q + 1'b1;
	assign is_posupd  = (cmd_q == sccd_pkg::CMD_SETFLAGS) || (cmd_q == sccd_pkg::CMD_SETPOS);

	// Mark later active servos that will also be written by this command
	always_comb begin
		for (int j = 0; j < NUM_SERVOS; j++) begin
			later_wr[j] = (sccd_pkg::CNT_W'(j) < n_act) && (sccd_pkg::CNT_W'(j) > cnt_q) &&
				(((cmd_q == sccd_pkg::CMD_SETFLAGS) &&
					(arg_q[0] || (arg_q[3] && (flags_q[j] != 2'b00)))) ||
				((cmd_q == sccd_pkg::CMD_SETPOS) && (flags_q[j] != 2'b00)));
		end
	end

	// Decide what the current servo does
	always_comb begin
		flag_n     = flag_i;
		wr_pos     = 1'b0;
		wr_cache   = 1'b0;
		pos_n      = arg_q;
		emit       = 1'b0;
		emit_kind  = sccd_pkg::KIND_UPDATE;
		emit_val   = arg_q;
		emit_rtype = sccd_pkg::RT_POSITION;
		emit_last  = 1'b1;
		case (cmd_q)
			sccd_pkg::CMD_LISTEN: begin
				if (arg_q == sccd_pkg::ALL_SERVOS || match) flag_n = flag_i | 2'b10;
			end
			sccd_pkg::CMD_IGNORE: begin
				if (arg_q == sccd_pkg::ALL_SERVOS || match) flag_n = 2'b00;
			end
			sccd_pkg::CMD_ONESHOT: begin
				if (arg_q == sccd_pkg::ALL_SERVOS || match) flag_n = flag_i | 2'b01;
			end
			sccd_pkg::CMD_SETFLAGS: begin
				wr_pos = arg_q[0] || (arg_q[3] && fnz);
				pos_n  = (arg_q[3] && fnz) ? sccd_pkg::CMD2CUR_POS : cached_q[idx];
			end
			sccd_pkg::CMD_SETPOS: begin
				wr_pos = fnz;
				pos_n  = arg_q;
			end
			sccd_pkg::CMD_SETCACHED: begin
				wr_cache = fnz;
			end
			sccd_pkg::CMD_QCURRENT: begin
				emit       = match;
				emit_kind  = sccd_pkg::KIND_REPLY;
				emit_val   = sccd_pkg::REPLY_CURRENT;
				emit_rtype = sccd_pkg::RT_CURRENT;
			end
			sccd_pkg::CMD_QPOSITION: begin
				emit       = match;
				emit_kind  = sccd_pkg::KIND_REPLY;
				emit_val   = sccd_pkg::REPLY_POSITION;
				emit_rtype = sccd_pkg::RT_POSITION;
			end
			sccd_pkg::CMD_QVERSION: begin
				emit       = match;
				emit_kind  = sccd_pkg::KIND_REPLY;
				emit_val   = sccd_pkg::VERSION_CODE;
				emit_rtype = sccd_pkg::RT_VERSION;
			end
			default: begin
			end
		endcase
		if (cmd_q inside {sccd_pkg::CMD_SETFLAGS, sccd_pkg::CMD_SETPOS,
				sccd_pkg::CMD_SETCACHED}) begin
			flag_n = (chain_en_q && match) ? 2'b01 : (flag_i & 2'b10);
		end
		if (is_posupd) begin
			emit      = wr_pos;
			emit_val  = pos_n;
			emit_last = ~|later_wr;
		end
	end

	// Take a command, step the walk, finish when all active servos are seen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			cmd_q      <= '0;
			arg_q      <= '0;
			tgt_q      <= '0;
			chain_q    <= sccd_pkg::CHAIN_OFF;
			chain_en_q <= 1'b0;
			found_q    <= 1'b0;
			cnt_q      <= '0;
		end else if (q_pop) begin
			busy_q     <= 1'b1;
			cmd_q      <= q_entry.cmd;
			arg_q      <= q_entry.arg;
			tgt_q      <= q_entry.arg;
			chain_en_q <= 1'b0;
			found_q    <= 1'b0;
			cnt_q      <= '0;
			case (q_entry.cmd)
				sccd_pkg::CMD_LISTEN, sccd_pkg::CMD_IGNORE: begin
					chain_q <= sccd_pkg::CHAIN_OFF;
				end
				sccd_pkg::CMD_ONESHOT: begin
					if (q_entry.arg != sccd_pkg::ALL_SERVOS &&
							q_entry.arg >= sccd_pkg::CHAIN_BASE) begin
						chain_q <= q_entry.arg - sccd_pkg::CHAIN_BASE;
						tgt_q   <= q_entry.arg - sccd_pkg::CHAIN_BASE;
					end else begin
						chain_q <= sccd_pkg::CHAIN_OFF;
					end
				end
				sccd_pkg::CMD_SETFLAGS, sccd_pkg::CMD_SETPOS, sccd_pkg::CMD_SETCACHED: begin
					if (chain_q != sccd_pkg::CHAIN_OFF) begin
						chain_q    <= chain_next;
						tgt_q      <= chain_next;
						chain_en_q <= (chain_next != sccd_pkg::CHAIN_OFF);
					end
				end
				default: begin
				end
			endcase
		end else if (busy_q) begin
			if (!walking) begin
				busy_q <= 1'b0;
			end else if (step) begin
				cnt_q   <= cnt_q + 1'b1;
				found_q <= found_q || match;
			end
		end
	end

	// Update per-servo state on each step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_SERVOS; k++) begin
				flags_q[k]  <= '0;
				cached_q[k] <= '0;
			end
		end else if (step) begin
			flags_q[idx] <= flag_n;
			if (wr_cache) cached_q[idx] <= arg_q;
		end
	end

	// Load a result or drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			out_kind_q  <= emit_kind;
			out_idx_q   <= cnt_q[sccd_pkg::IDX_W-1:0];
			out_val_q   <= emit_val;
			out_rtype_q <= emit_rtype;
			out_last_q  <= emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_val_q, out_idx_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_rtype_q, out_kind_q};

endmodule
`default_nettype wire

/* src/sccd_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sccd_checker: port checks for the servo chain command decoder
// Watches the result channel and flags malformed transactions.
// ----------------------------------------------------------------------------
module sccd_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [15:0] m_tdata,
	input wire        m_tlast,
	input wire [2:0]  m_tuser
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
			$stable(m_tlast))
		else $error("result changed while stalled");

	// A reply is the only result of its command
	a_reply_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("reply not marked last");

	// Position updates carry a zero reply type
	a_update_type: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tuser[2:1] == 2'd0)
		else $error("update with nonzero reply type");

	// Reply data agrees with its type
	a_reply_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			(m_tuser[2:1] == 2'd1 && m_tdata[13:4] == 10'd0) ||
			(m_tuser[2:1] == 2'd0 && m_tdata[13:4] == 10'd1) ||
			(m_tuser[2:1] == 2'd2 && m_tdata[13:4] == 10'd5))
		else $error("reply value does not match reply type");

endmodule

bind servo_chain_command_decoder_top sccd_checker u_sccd_checker (.*);
`default_nettype wire

/* dv/servo_chain_command_decoder_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_chain_command_decoder_checker: result predictor and scoreboard
// Watches the byte, result and register channels of the decoder. Keeps its
// own copy of the servo state, predicts the results of every accepted byte
// and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module servo_chain_command_decoder_checker #(
	parameter int NUM_SERVOS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [15:0] m_tdata,   // [3:0] servo_index, [13:4] value, [15:14] zero
	input  wire         m_tlast,
	input  wire  [2:0]  m_tuser,   // [0] kind, [2:1] reply_type
	input  wire         cfg_valid,
	input  wire         cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [63:0] cfg_data,
	output int          failures,
	output int          outstanding
);

	typedef struct packed {
		logic                         kind;
		logic [sccd_pkg::IDX_W-1:0]   servo_index;
		logic [sccd_pkg::POS_W-1:0]   value;
		logic [sccd_pkg::RTYPE_W-1:0] reply_type;
		logic                         last;
	} servo_result_t;

	servo_result_t servo_results_q[$];

	// Register copies
	logic [sccd_pkg::CNT_W-1:0] in_use;
	logic [sccd_pkg::IDS_W-1:0] ids;

	// Decoder state copies
	logic                       waiting_close;
	logic [sccd_pkg::CMD_W-1:0] cmd_hold;
	logic [sccd_pkg::ARG_W-1:0] arg_hold;
	logic [sccd_pkg::ARG_W-1:0] chain_addr;
	logic [1:0]                 flags     [NUM_SERVOS];
	logic [sccd_pkg::POS_W-1:0] cmd_pos   [NUM_SERVOS];
	logic [sccd_pkg::POS_W-1:0] cache_pos [NUM_SERVOS];

	// The last result of a command is held back until its tlast is known
	servo_result_t held;
	bit            have_held;
	int            fail_n;

	function automatic int active_servos();
		return (in_use > NUM_SERVOS) ? NUM_SERVOS : int'(in_use);
	endfunction

	// First active servo whose bus id equals id, or -1
	function automatic int lookup(input logic [sccd_pkg::ARG_W-1:0] id);
		int n;
		n = active_servos();
		for (int i = 0; i < n; i++)
			if ({2'b00, ids[i*8 +: 8]} == id)
				return i;
		return -1;
	endfunction

	// Apply a listen, ignore or one-shot listen to one flag pair
	function automatic logic [1:0] mark(input logic [sccd_pkg::CMD_W-1:0] cmd,
			input logic [1:0] f);
		case (cmd)
			sccd_pkg::CMD_LISTEN: return f | 2'b10;
			sccd_pkg::CMD_IGNORE: return 2'b00;
			default:              return f | 2'b01;
		endcase
	endfunction

	task automatic emit(input logic kind, input logic [sccd_pkg::IDX_W-1:0] idx,
			input logic [sccd_pkg::POS_W-1:0] value,
			input logic [sccd_pkg::RTYPE_W-1:0] rtype);
		if (have_held)
			servo_results_q.push_back(held);
		held = '{kind, idx, value, rtype, 1'b0};
		have_held = 1'b1;
	endtask

	task automatic run_servo_cmd(input logic [sccd_pkg::CMD_W-1:0] cmd,
			input logic [sccd_pkg::ARG_W-1:0] arg);
		int n;
		int m;
		logic [NUM_SERVOS-1:0] written;
		n = active_servos();
		written = '0;
		have_held = 1'b0;
		case (cmd)
			sccd_pkg::CMD_LISTEN, sccd_pkg::CMD_IGNORE, sccd_pkg::CMD_ONESHOT: begin
				chain_addr = sccd_pkg::CHAIN_OFF;
				if (arg == sccd_pkg::ALL_SERVOS) begin
					for (int i = 0; i < n; i++)
						flags[i] = mark(cmd, flags[i]);
				end else if (cmd == sccd_pkg::CMD_ONESHOT && arg >= sccd_pkg::CHAIN_BASE) begin
					chain_addr = arg - sccd_pkg::CHAIN_BASE;
					m = lookup(chain_addr);
					if (m >= 0)
						flags[m] = mark(sccd_pkg::CMD_ONESHOT, flags[m]);
				end else begin
					m = lookup(arg);
					if (m >= 0)
						flags[m] = mark(cmd, flags[m]);
				end
			end
			sccd_pkg::CMD_SETFLAGS: begin
				if (arg[0])
					for (int i = 0; i < n; i++) begin
						cmd_pos[i] = cache_pos[i];
						written[i] = 1'b1;
					end
				if (arg[3])
					for (int i = 0; i < n; i++)
						if (flags[i] != 2'b00) begin
							cmd_pos[i] = sccd_pkg::CMD2CUR_POS;
							written[i] = 1'b1;
						end
			end
			sccd_pkg::CMD_SETPOS: begin
				for (int i = 0; i < n; i++)
					if (flags[i] != 2'b00) begin
						cmd_pos[i] = arg;
						written[i] = 1'b1;
					end
			end
			sccd_pkg::CMD_SETCACHED: begin
				for (int i = 0; i < n; i++)
					if (flags[i] != 2'b00)
						cache_pos[i] = arg;
			end
			sccd_pkg::CMD_QCURRENT: begin
				m = lookup(arg);
				if (m >= 0)
					emit(sccd_pkg::KIND_REPLY, 4'(m), sccd_pkg::REPLY_CURRENT,
						sccd_pkg::RT_CURRENT);
			end
			sccd_pkg::CMD_QPOSITION: begin
				m = lookup(arg);
				if (m >= 0)
					emit(sccd_pkg::KIND_REPLY, 4'(m), sccd_pkg::REPLY_POSITION,
						sccd_pkg::RT_POSITION);
			end
			sccd_pkg::CMD_QVERSION: begin
				m = lookup(arg);
				if (m >= 0)
					emit(sccd_pkg::KIND_REPLY, 4'(m), sccd_pkg::VERSION_CODE,
						sccd_pkg::RT_VERSION);
			end
			default: begin
			end
		endcase

		// One update per written servo, in index order
		for (int i = 0; i < n; i++)
			if (written[i])
				emit(sccd_pkg::KIND_UPDATE, 4'(i), cmd_pos[i], sccd_pkg::RT_POSITION);

		// Drop one-shot flags and advance the chain after position commands
		if (cmd == sccd_pkg::CMD_SETFLAGS || cmd == sccd_pkg::CMD_SETPOS ||
				cmd == sccd_pkg::CMD_SETCACHED) begin
			for (int i = 0; i < n; i++)
				flags[i] = flags[i] & 2'b10;
			if (chain_addr != sccd_pkg::CHAIN_OFF) begin
				chain_addr = chain_addr + 10'd1;
				if (chain_addr != sccd_pkg::CHAIN_OFF) begin
					m = lookup(chain_addr);
					if (m >= 0)
						flags[m] = 2'b01;
				end
			end
		end

		if (have_held) begin
			held.last = 1'b1;
			servo_results_q.push_back(held);
			have_held = 1'b0;
		end
	endtask

	task automatic decode_byte(input logic [7:0] b);
		if (!waiting_close) begin
			if (!b[7]) begin
				waiting_close = 1'b1;
				cmd_hold = b[6:3];
				arg_hold[2:0] = b[2:0];
			end
		end else begin
			waiting_close = 1'b0;
			if (b[7]) begin
				arg_hold[9:3] = b[6:0];
				run_servo_cmd(cmd_hold, arg_hold);
			end
		end
	endtask

	// Compare results, track register writes, predict from accepted bytes
	always @(posedge clk or negedge arst_n) begin : monitor
		servo_result_t got;
		servo_result_t want;
		if (!arst_n) begin
			in_use = 5'd16;
			ids = '0;
			waiting_close = 1'b0;
			cmd_hold = '0;
			arg_hold = '0;
			chain_addr = sccd_pkg::CHAIN_OFF;
			for (int i = 0; i < NUM_SERVOS; i++) begin
				flags[i] = 2'b00;
				cmd_pos[i] = '0;
				cache_pos[i] = '0;
			end
			servo_results_q.delete();
			have_held = 1'b0;
			fail_n = 0;
			failures <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.kind = m_tuser[0];
				got.servo_index = m_tdata[3:0];
				got.value = m_tdata[13:4];
				got.reply_type = m_tuser[2:1];
				got.last = m_tlast;
				if (servo_results_q.size() == 0) begin
					fail_n++;
					if (fail_n <= 10)
						$display("%0t: result with none pending:", $realtime,
							" kind=%0d idx=%0d value=%0d type=%0d last=%0d",
							got.kind, got.servo_index, got.value, got.reply_type,
							got.last);
				end else begin
					want = servo_results_q.pop_front();
					if (got.kind !== want.kind || got.servo_index !== want.servo_index ||
							got.value !== want.value || got.reply_type !== want.reply_type ||
							got.last !== want.last) begin
						fail_n++;
						if (fail_n <= 10)
							$display("%0t: result mismatch:", $realtime,
								" want kind=%0d idx=%0d value=%0d type=%0d last=%0d,",
								want.kind, want.servo_index, want.value,
								want.reply_type, want.last,
								" got kind=%0d idx=%0d value=%0d type=%0d last=%0d",
								got.kind, got.servo_index, got.value,
								got.reply_type, got.last);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					sccd_pkg::CFG_SERVOS_IN_USE: in_use = cfg_data[sccd_pkg::CNT_W-1:0];
					sccd_pkg::CFG_IDS_LOW:       ids[63:0] = cfg_data;
					sccd_pkg::CFG_IDS_HIGH:      ids[127:64] = cfg_data;
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready)
				decode_byte(s_tdata);
			failures <= fail_n;
			outstanding <= servo_results_q.size();
		end
	end

endmodule

/* dv/tb_servo_chain_command_decoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_servo_chain_command_decoder_top: testbench of the servo command decoder
// Sends directed and random command frames over several register settings,
// stalls both streams in random bursts and lets the checker score results.
// ----------------------------------------------------------------------------
module tb_servo_chain_command_decoder_top;

	localparam int        PERIOD       = 8;
	localparam int        NUM_SERVOS   = 16;
	localparam int        DRAIN_CYCLES = 80;
	localparam int        IDLE_LIMIT   = 4000;
	localparam int        PHASE_BYTES  = 12;
	localparam logic [1:0] CFG_NO_REG  = 2'd3;

	// Ways of filling the bus id table
	localparam int IDS_CONSECUTIVE = 0;
	localparam int IDS_POOL        = 1;
	localparam int IDS_RANDOM      = 2;
	localparam int IDS_ALL_ONES    = 3;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic [7:0]  s_tdata   = 8'h00;
	logic        m_tready  = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [63:0] cfg_data  = 64'd0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [15:0] m_tdata;
	wire         m_tlast;
	wire  [2:0]  m_tuser;
	wire         cfg_ready;
	int          failures;
	int          outstanding;

	bit                         calm = 1'b0;
	int                         stall_left = 0;
	int                         idle_cycles = 0;
	int                         sent_bytes = 0;
	logic [sccd_pkg::IDS_W-1:0] ids_now;

	always #(PERIOD / 2) clk = ~clk;

	servo_chain_command_decoder_top #(
		.NUM_SERVOS(NUM_SERVOS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	servo_chain_command_decoder_checker #(
		.NUM_SERVOS(NUM_SERVOS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.failures   (failures),
		.outstanding(outstanding)
	);

	// Stall the result stream in random bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 8);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Abort when no transaction moves on any channel for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Offer one byte, sometimes with a random gap in front, and hold until accepted
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		sent_bytes++;
	endtask

	task automatic send_frame(input logic [sccd_pkg::CMD_W-1:0] cmd,
			input logic [sccd_pkg::ARG_W-1:0] arg);
		send_byte({1'b0, cmd, arg[2:0]});
		send_byte({1'b1, arg[9:3]});
	endtask

	// Drop valid, wait for every pending result, then let the walker drain
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [sccd_pkg::IDS_W-1:0] make_ids(input int mode,
			input logic [7:0] base);
		logic [sccd_pkg::IDS_W-1:0] t;
		for (int k = 0; k < NUM_SERVOS; k++)
			case (mode)
				IDS_CONSECUTIVE: t[k*8 +: 8] = base + 8'(k);
				IDS_POOL:        t[k*8 +: 8] = 8'h40 + 8'($urandom_range(0, 7));
				IDS_ALL_ONES:    t[k*8 +: 8] = 8'hFF;
				default:         t[k*8 +: 8] = 8'($urandom);
			endcase
		return t;
	endfunction

	// Load a servo count and an id table; junk rides in the unused count bits
	task automatic apply_setup(input logic [sccd_pkg::CNT_W-1:0] n,
			input logic [sccd_pkg::IDS_W-1:0] t);
		logic [63:0] count_word;
		count_word = {$urandom, $urandom};
		count_word[sccd_pkg::CNT_W-1:0] = n;
		ids_now = t;
		write_reg(sccd_pkg::CFG_IDS_LOW, t[63:0]);
		write_reg(sccd_pkg::CFG_IDS_HIGH, t[127:64]);
		write_reg(sccd_pkg::CFG_SERVOS_IN_USE, count_word);
	endtask

	// Mostly arguments that hit a configured id, the broadcast or the chain
	function automatic logic [sccd_pkg::ARG_W-1:0] pick_arg();
		int k;
		k = $urandom_range(0, NUM_SERVOS - 1);
		case ($urandom_range(0, 5))
			0, 1:    return {2'b00, ids_now[k*8 +: 8]};
			2:       return sccd_pkg::ALL_SERVOS;
			3:       return sccd_pkg::CHAIN_BASE + {2'b00, ids_now[k*8 +: 8]};
			4:       return 10'($urandom_range(0, 255));
			default: return 10'($urandom_range(0, 1023));
		endcase
	endfunction

	initial begin : stimulus
		int n_tab [5];
		int mode_tab [5];
		int start_bytes;
		logic [sccd_pkg::CMD_W-1:0] cmd;
		n_tab = '{16, 0, 1, 31, 17};
		mode_tab = '{IDS_POOL, IDS_RANDOM, IDS_CONSECUTIVE, IDS_ALL_ONES, IDS_POOL};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: ids 0x10..0x1F on all sixteen servos
		write_reg(CFG_NO_REG, {$urandom, $urandom});
		apply_setup(5'd16, make_ids(IDS_CONSECUTIVE, 8'h10));
		send_frame(sccd_pkg::CMD_LISTEN, sccd_pkg::ALL_SERVOS);
		send_frame(sccd_pkg::CMD_SETPOS, 10'd1023);
		send_frame(sccd_pkg::CMD_SETFLAGS, 10'd9);
		send_frame(sccd_pkg::CMD_QCURRENT, 10'h010);
		send_frame(sccd_pkg::CMD_QPOSITION, 10'h01F);
		send_frame(sccd_pkg::CMD_QVERSION, 10'h015);
		send_frame(sccd_pkg::CMD_QVERSION, 10'h040);
		send_frame(sccd_pkg::CMD_IGNORE, 10'h013);
		send_frame(sccd_pkg::CMD_IGNORE, sccd_pkg::ALL_SERVOS);
		send_frame(sccd_pkg::CMD_ONESHOT, sccd_pkg::CHAIN_BASE + 10'h010);
		send_frame(sccd_pkg::CMD_SETPOS, 10'd0);
		send_frame(4'd15, 10'd0);
		// Frame dropped by a low closing byte, then a stray high byte
		send_byte({1'b0, sccd_pkg::CMD_SETPOS, 3'b111});
		send_byte(8'h00);
		send_byte(8'hFF);

		// Random: one setting per phase, the last one without idling
		for (int ph = 0; ph < 6; ph++) begin
			settle();
			if (ph < 5)
				apply_setup(5'(n_tab[ph]), make_ids(mode_tab[ph], 8'($urandom)));
			else
				apply_setup(5'($urandom_range(0, 31)),
					make_ids(IDS_CONSECUTIVE, 8'($urandom)));
			calm = (ph == 5);
			start_bytes = sent_bytes;
			while (sent_bytes - start_bytes < PHASE_BYTES) begin
				case ($urandom_range(0, 9))
					0: send_byte(8'($urandom));
					1: begin
						send_byte({1'b0, 7'($urandom)});
						send_byte({1'b0, 7'($urandom)});
					end
					default: begin
						if ($urandom_range(0, 5) == 0)
							cmd = 4'($urandom_range(0, 15));
						else
							cmd = 4'($urandom_range(0, 8));
						send_frame(cmd, pick_arg());
					end
				endcase
			end
		end

		settle();
		if (failures == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* filelist.f */
src/sccd_pkg.sv
src/sccd_front.sv
src/sccd_queue.sv
src/sccd_back.sv
src/servo_chain_command_decoder_top.sv
src/sccd_checker.sv
dv/servo_chain_command_decoder_checker.sv
dv/tb_servo_chain_command_decoder_top.sv
